// ===== rtl/ssd_pkg.sv =====
// Shared types and constants for the sorted symmetric difference unit.
// Used by ssd_lists and sorted_symmetric_difference_unit; depends on nothing.
`default_nettype none

package ssd_pkg;

  // Width of one stored element and of one result value
  localparam int unsigned VALUE_W = 32;

  // Request kinds carried on in_tuser
  localparam logic [1:0] FUNC_LOAD_A = 2'd0;
  localparam logic [1:0] FUNC_LOAD_B = 2'd1;
  localparam logic [1:0] FUNC_START  = 2'd2;

  // Write strobes and data from the sequencer to the list store
  typedef struct packed {
    logic               en_a;
    logic               en_b;
    logic [VALUE_W-1:0] data;
  } lists_wr_t;

endpackage : ssd_pkg

`default_nettype wire

// ===== rtl/ssd_lists.sv =====
// Storage for the two sorted lists: one write port shared by both lists
// and one registered read port per list. Depends on ssd_pkg.
`default_nettype none

module ssd_lists #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned IDXW  = 4
) (
  input  wire logic                          clk,
  input  wire ssd_pkg::lists_wr_t            wr,
  input  wire logic [IDXW-1:0]               wr_addr,
  input  wire logic [IDXW-1:0]               rd_addr_a,
  input  wire logic [IDXW-1:0]               rd_addr_b,
  output      logic [ssd_pkg::VALUE_W-1:0]   rd_data_a,
  output      logic [ssd_pkg::VALUE_W-1:0]   rd_data_b
);

  logic [ssd_pkg::VALUE_W-1:0] mem_a [DEPTH];
  logic [ssd_pkg::VALUE_W-1:0] mem_b [DEPTH];
  logic [ssd_pkg::VALUE_W-1:0] rd_data_a_r;
  logic [ssd_pkg::VALUE_W-1:0] rd_data_b_r;

  // Store an appended element
  always_ff @(posedge clk) begin
    if (wr.en_a) begin
      mem_a[wr_addr] <= wr.data;
    end
    if (wr.en_b) begin
      mem_b[wr_addr] <= wr.data;
    end
  end

  // Fetch the heads for the next walk step
  always_ff @(posedge clk) begin
    rd_data_a_r <= mem_a[rd_addr_a];
    rd_data_b_r <= mem_b[rd_addr_b];
  end

  assign rd_data_a = rd_data_a_r;
  assign rd_data_b = rd_data_b_r;

endmodule : ssd_lists

`default_nettype wire

// ===== rtl/sorted_symmetric_difference_unit.sv =====
// Sorted symmetric difference: loads are accepted while idle and leave the unit ready
// again at once. A start request walks both lists with one shared comparator; each
// step consumes the smaller head, or both heads when they are equal, and an output
// stall holds the walk. in_tready stays low for that walk. Uses ssd_pkg, ssd_lists.
// Results leave through an output register, one per cycle at best.
// Synchronous active-low reset clears state, counts, heads, overflow and valid flags.
`default_nettype none

module sorted_symmetric_difference_unit #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] value
  input  wire logic [1:0]  in_tuser,   // [1:0] func
  // result channel
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [31:0] out_tdata,  // [31:0] value_res
  output      logic [1:0]  out_tuser,  // [0] empty_res, [1] overflow
  output      logic        out_tlast
);

  localparam int unsigned IDXW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNTW = $clog2(DEPTH + 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_WALK = 1'b1;

  // control state
  logic            state_r,    state_nxt;
  logic [CNTW-1:0] cnt_a_r,    cnt_a_nxt;
  logic [CNTW-1:0] cnt_b_r,    cnt_b_nxt;
  logic [CNTW-1:0] ia_r,       ia_nxt;
  logic [CNTW-1:0] ib_r,       ib_nxt;
  logic            dropped_r,  dropped_nxt;
  logic            hold_v_r,   hold_v_nxt;
  logic            out_vld_r,  out_vld_nxt;
  // payload
  logic [31:0]     hold_val_r, hold_val_nxt;
  logic [31:0]     out_data_r, out_data_nxt;
  logic            out_empty_r, out_empty_nxt;
  logic            out_ovf_r,  out_ovf_nxt;
  logic            out_last_r, out_last_nxt;

  // walk signals
  logic [31:0]     rd_a;
  logic [31:0]     rd_b;
  logic            a_has;
  logic            b_has;
  logic            a_lt;
  logic            b_lt;
  logic            take_a;
  logic            take_b;
  logic            drop_both;
  logic            finish;
  logic            out_free;
  logic            stall;
  logic            in_fire;
  logic [31:0]     new_val;

  ssd_pkg::lists_wr_t wr;
  logic [IDXW-1:0]    wr_addr;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_vld_r || out_tready;

  // Append requests go to the tail of their list
  always_comb begin
    wr.en_a = in_fire && (in_tuser == ssd_pkg::FUNC_LOAD_A) && (cnt_a_r < CNTW'(DEPTH));
    wr.en_b = in_fire && (in_tuser == ssd_pkg::FUNC_LOAD_B) && (cnt_b_r < CNTW'(DEPTH));
    wr.data = in_tdata;
    wr_addr = (in_tuser == ssd_pkg::FUNC_LOAD_B) ? cnt_b_r[IDXW-1:0] : cnt_a_r[IDXW-1:0];
  end

  ssd_lists #(
    .DEPTH (DEPTH),
    .IDXW  (IDXW)
  ) u_lists (
    .clk       (clk),
    .wr        (wr),
    .wr_addr   (wr_addr),
    .rd_addr_a (ia_nxt[IDXW-1:0]),
    .rd_addr_b (ib_nxt[IDXW-1:0]),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b)
  );

  // Shared comparator: pick what the current heads do
  always_comb begin
    a_has     = (ia_r < cnt_a_r);
    b_has     = (ib_r < cnt_b_r);
    a_lt      = ($signed(rd_a) < $signed(rd_b));
    b_lt      = ($signed(rd_b) < $signed(rd_a));
    take_a    = 1'b0;
    take_b    = 1'b0;
    drop_both = 1'b0;
    finish    = 1'b0;
    if (a_has && b_has) begin
      if (a_lt) begin
        take_a = 1'b1;
      end else if (b_lt) begin
        take_b = 1'b1;
      end else begin
        drop_both = 1'b1;
      end
    end else if (a_has) begin
      take_a = 1'b1;
    end else if (b_has) begin
      take_b = 1'b1;
    end else begin
      finish = 1'b1;
    end
    new_val = take_a ? rd_a : rd_b;
    // hold when the held result or the final one cannot move out
    stall = (((take_a || take_b) && hold_v_r) || finish) && !out_free;
  end

  // Sequencer next state
  always_comb begin
    state_nxt     = state_r;
    cnt_a_nxt     = cnt_a_r;
    cnt_b_nxt     = cnt_b_r;
    ia_nxt        = ia_r;
    ib_nxt        = ib_r;
    dropped_nxt   = dropped_r;
    hold_v_nxt    = hold_v_r;
    hold_val_nxt  = hold_val_r;
    out_vld_nxt   = out_vld_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_empty_nxt = out_empty_r;
    out_ovf_nxt   = out_ovf_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_tuser)
            ssd_pkg::FUNC_LOAD_A: begin
              if (wr.en_a) begin
                cnt_a_nxt = cnt_a_r + CNTW'(1);
              end else begin
                dropped_nxt = 1'b1;
              end
            end
            ssd_pkg::FUNC_LOAD_B: begin
              if (wr.en_b) begin
                cnt_b_nxt = cnt_b_r + CNTW'(1);
              end else begin
                dropped_nxt = 1'b1;
              end
            end
            ssd_pkg::FUNC_START: begin
              ia_nxt     = '0;
              ib_nxt     = '0;
              hold_v_nxt = 1'b0;
              state_nxt  = S_WALK;
            end
            default: begin
            end
          endcase
        end
      end
      S_WALK: begin
        if (!stall) begin
          // advance the heads
          if (take_a || drop_both) begin
            ia_nxt = ia_r + CNTW'(1);
          end
          if (take_b || drop_both) begin
            ib_nxt = ib_r + CNTW'(1);
          end
          // a new result pushes the held one out, not last
          if (take_a || take_b) begin
            if (hold_v_r) begin
              out_vld_nxt   = 1'b1;
              out_data_nxt  = hold_val_r;
              out_empty_nxt = 1'b0;
              out_ovf_nxt   = dropped_r;
              out_last_nxt  = 1'b0;
            end
            hold_v_nxt   = 1'b1;
            hold_val_nxt = new_val;
          end
          // end of run: release the held result as last, or an empty marker
          if (finish) begin
            out_vld_nxt   = 1'b1;
            out_data_nxt  = hold_v_r ? hold_val_r : '0;
            out_empty_nxt = !hold_v_r;
            out_ovf_nxt   = dropped_r;
            out_last_nxt  = 1'b1;
            hold_v_nxt    = 1'b0;
            cnt_a_nxt     = '0;
            cnt_b_nxt     = '0;
            ia_nxt        = '0;
            ib_nxt        = '0;
            dropped_nxt   = 1'b0;
            state_nxt     = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_a_r   <= '0;
      cnt_b_r   <= '0;
      ia_r      <= '0;
      ib_r      <= '0;
      dropped_r <= 1'b0;
      hold_v_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_a_r   <= cnt_a_nxt;
      cnt_b_r   <= cnt_b_nxt;
      ia_r      <= ia_nxt;
      ib_r      <= ib_nxt;
      dropped_r <= dropped_nxt;
      hold_v_r  <= hold_v_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    hold_val_r  <= hold_val_nxt;
    out_data_r  <= out_data_nxt;
    out_empty_r <= out_empty_nxt;
    out_ovf_r   <= out_ovf_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = {out_ovf_r, out_empty_r};
  assign out_tlast  = out_last_r;

  // Heads never run past the stored counts, counts never past DEPTH
  a_heads_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ia_r <= cnt_a_r) && (ib_r <= cnt_b_r))
    else $error("walk head beyond list count");

  a_counts_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_a_r <= CNTW'(DEPTH)) && (cnt_b_r <= CNTW'(DEPTH)))
    else $error("list count beyond DEPTH");

  // No result is held back once the walk is over
  a_hold_only_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !hold_v_r)
    else $error("held result left in idle");

  // Leaving the walk always presents a last result
  a_finish_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK && state_nxt == S_IDLE) |=> (out_vld_r && out_last_r))
    else $error("run ended without last result");

  // An empty marker is always the last result
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_empty_r) |-> out_last_r)
    else $error("empty marker not last");

endmodule : sorted_symmetric_difference_unit

`default_nettype wire
